### sv/biou_pkg.sv
// Shared types and constants for the best-IoU box matcher.
// Used by the controller, the datapath and the top level; no dependencies.
package biou_pkg;

  localparam int unsigned DEF_MAX_TRUTH_BOXES = 32;
  localparam int unsigned COORD_W = 18;
  localparam int unsigned SIZE_W = 17;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned IOU_W = 16;
  localparam int unsigned CMP_W = 6;
  localparam logic [IOU_W-1:0] THRESH_RESET = 16'd39322;
  localparam logic [IOU_W-1:0] IOU_SAT = 16'hFFFF;

  // Item kinds carried in the slave-side tuser.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic append;
    logic start;
    logic rd;
    logic ovl;
    logic mul;
    logic uni;
    logic sat;
    logic div_init;
    logic div_step;
    logic upd;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_end;
    logic sentinel;
    logic uni_zero;
    logic inter_eq;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

### sv/best_iou_box_matcher.sv
// Top level of the best-IoU box matcher: stream ports, controller, datapath.
// Depends on biou_pkg, biou_ctrl and biou_dp.
//
// The block keeps up to MAX_TRUTH_BOXES truth boxes. An item with tuser
// clear empties the list and an append item stores one box, each without
// leaving the idle state; appends to a full list are dropped. A query item
// walks the stored boxes in order, stops at the first box whose center x is
// not above zero, and returns one result item with the best IoU (unsigned
// Q0.16), the threshold flag and the number of boxes compared. Each compared
// box passes read, overlap, multiply, union and check steps, a division adds
// a 16-step radix-2 divider and an update step, a full overlap adds only the
// update step. A walk ended by a sentinel box also passes its read step, and
// the block is ready for the next item in the cycle after the result is
// loaded. The divider and the single store read port set the length of a
// query. A new item is accepted while a finished result waits on the master
// side.
module best_iou_box_matcher #(
  parameter int unsigned MAX_TRUTH_BOXES = biou_pkg::DEF_MAX_TRUTH_BOXES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // box_x[17:0], box_y[35:18], box_w[52:36], box_h[69:53]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // top_iou[15:0], above_threshold[16], boxes_compared[22:17]
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data     // iou_threshold
);
  import biou_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [IOU_W-1:0] best;
  logic             above;
  logic [CMP_W-1:0] cmp;

  biou_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_func  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  biou_dp #(
    .MAX_TRUTH_BOXES (MAX_TRUTH_BOXES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_x      ($signed(s_axis_tdata[17:0])),
    .in_y      ($signed(s_axis_tdata[35:18])),
    .in_w      (s_axis_tdata[52:36]),
    .in_h      (s_axis_tdata[69:53]),
    .thr_we    (cfg_wr_en),
    .thr_data  (cfg_wr_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_best  (best),
    .out_above (above),
    .out_cmp   (cmp)
  );

  assign m_axis_tdata = {1'b0, cmp, above, best};

endmodule

### sv/biou_ctrl.sv
// Controller state machine of the best-IoU box matcher.
// Depends on biou_pkg; drives the datapath by dp_cmd_t and reads dp_stat_t.
module biou_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_func,
  output logic               in_ready,
  input  biou_pkg::dp_stat_t stat,
  output biou_pkg::dp_cmd_t  cmd
);
  import biou_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_OVL  = 9'b000000100,
    S_MUL  = 9'b000001000,
    S_UNI  = 9'b000010000,
    S_CHK  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_UPD  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   take;

  assign in_ready = (state == S_IDLE);
  assign take = in_valid && in_ready;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (func_t'(in_func))
            FUNC_CLEAR:  cmd.clear = 1'b1;
            FUNC_APPEND: cmd.append = 1'b1;
            FUNC_QUERY: begin
              cmd.start = 1'b1;
              state_next = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        if (stat.at_end) begin
          state_next = S_FIN;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_OVL;
        end
      end
      S_OVL: begin
        if (stat.sentinel) begin
          state_next = S_FIN;
        end else begin
          cmd.ovl = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_UNI;
      end
      S_UNI: begin
        cmd.uni = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        // A zero union leaves the best value alone; a full overlap saturates.
        if (stat.uni_zero) begin
          state_next = S_RD;
        end else if (stat.inter_eq) begin
          cmd.sat = 1'b1;
          state_next = S_UPD;
        end else begin
          cmd.div_init = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        state_next = S_RD;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

### sv/biou_dp.sv
// Datapath of the best-IoU box matcher: box store, overlap, products,
// union, a radix-2 divider and the output register. Depends on biou_pkg.
module biou_dp #(
  parameter int unsigned MAX_TRUTH_BOXES = biou_pkg::DEF_MAX_TRUTH_BOXES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  biou_pkg::dp_cmd_t                  cmd,
  output biou_pkg::dp_stat_t                 stat,
  input  logic signed [biou_pkg::COORD_W-1:0] in_x,
  input  logic signed [biou_pkg::COORD_W-1:0] in_y,
  input  logic [biou_pkg::SIZE_W-1:0]        in_w,
  input  logic [biou_pkg::SIZE_W-1:0]        in_h,
  input  logic                               thr_we,
  input  logic [biou_pkg::IOU_W-1:0]         thr_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [biou_pkg::IOU_W-1:0]         out_best,
  output logic                               out_above,
  output logic [biou_pkg::CMP_W-1:0]         out_cmp
);
  import biou_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_TRUTH_BOXES + 1);
  localparam int unsigned IDX_W = (MAX_TRUTH_BOXES > 1) ? $clog2(MAX_TRUTH_BOXES) : 1;
  localparam int unsigned BOX_W = 2 * COORD_W + 2 * SIZE_W;
  localparam int unsigned EDGE_W = COORD_W + 2;      // 2c +/- s
  localparam int unsigned OVL_W = EDGE_W + 1;        // right - left
  localparam int unsigned MAG_W = SIZE_W + 2;        // positive overlap, up to 2s
  localparam int unsigned AREA_W = 2 * SIZE_W;
  localparam int unsigned UNI_W = 2 * MAG_W;         // also holds 4 * (a + b)
  localparam int unsigned REM_W = UNI_W + 1;
  localparam int unsigned DCNT_W = $clog2(IOU_W);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TRUTH_BOXES);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(IOU_W - 1);

  // Box store.
  logic [BOX_W-1:0] mem [MAX_TRUTH_BOXES];
  logic [BOX_W-1:0] rd_data;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;

  // Query box and per-box working registers.
  logic signed [COORD_W-1:0] qx, qy;
  logic [SIZE_W-1:0]         qw, qh;
  logic [MAG_W-1:0]          ow, oh;
  logic                      o_neg;
  logic [UNI_W-1:0]          inter, uni;
  logic [AREA_W-1:0]         qarea, tarea;
  logic [REM_W-1:0]          rem;
  logic [IOU_W-1:0]          quo, best;
  logic [DCNT_W-1:0]         dcnt;
  logic [CMP_W-1:0]          compared;
  logic [IOU_W-1:0]          thr;

  logic signed [COORD_W-1:0] tx, ty;
  logic [SIZE_W-1:0]         tw, th;
  logic signed [OVL_W-1:0]   ovl_x, ovl_y;
  logic [REM_W-1:0]          rem2;
  logic [AREA_W:0]           area_sum;

  assign {tx, ty, tw, th} = rd_data;

  // Overlap of two center-width intervals, in doubled units.
  function automatic logic signed [OVL_W-1:0] overlap2(
    input logic signed [COORD_W-1:0] c1,
    input logic [SIZE_W-1:0]         s1,
    input logic signed [COORD_W-1:0] c2,
    input logic [SIZE_W-1:0]         s2
  );
    logic signed [EDGE_W-1:0] l1, l2, r1, r2, lft, rgt;
    l1 = $signed({c1[COORD_W-1], c1, 1'b0}) - $signed({2'b00, s1});
    r1 = $signed({c1[COORD_W-1], c1, 1'b0}) + $signed({2'b00, s1});
    l2 = $signed({c2[COORD_W-1], c2, 1'b0}) - $signed({2'b00, s2});
    r2 = $signed({c2[COORD_W-1], c2, 1'b0}) + $signed({2'b00, s2});
    lft = (l1 > l2) ? l1 : l2;
    rgt = (r1 < r2) ? r1 : r2;
    return OVL_W'(rgt) - OVL_W'(lft);
  endfunction

  assign ovl_x = overlap2(qx, qw, tx, tw);
  assign ovl_y = overlap2(qy, qh, ty, th);
  assign rem2 = {rem[REM_W-2:0], 1'b0};
  assign area_sum = {1'b0, qarea} + {1'b0, tarea};

  // Status back to the controller.
  always_comb begin
    stat.at_end   = (idx == count);
    stat.sentinel = (tx[COORD_W-1] || (tx == '0));
    stat.uni_zero = (uni == '0);
    stat.inter_eq = (inter == uni);
    stat.div_last = (dcnt == DCNT_LAST);
    stat.out_free = !out_valid || out_ready;
  end

  // Store writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.append && (count < MAX_CNT)) begin
      mem[count[IDX_W-1:0]] <= {in_x, in_y, in_w, in_h};
    end
    if (cmd.rd) begin
      rd_data <= mem[idx[IDX_W-1:0]];
    end
  end

  // Fill count of the store.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
    end else if (cmd.append && (count < MAX_CNT)) begin
      count <= count + 1'b1;
    end
  end

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst)         thr <= THRESH_RESET;
    else if (thr_we) thr <= thr_data;
  end

  // Walk control: query box, index, compared count and best value.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx <= in_x;
      qy <= in_y;
      qw <= in_w;
      qh <= in_h;
      idx <= '0;
      compared <= '0;
      best <= '0;
    end else begin
      if (cmd.ovl) begin
        idx <= idx + 1'b1;
        compared <= compared + 1'b1;
      end
      if (cmd.upd && (quo > best)) begin
        best <= quo;
      end
    end
  end

  // Overlaps, then products, then union.
  always_ff @(posedge clk) begin
    if (cmd.ovl) begin
      o_neg <= ovl_x[OVL_W-1] || ovl_y[OVL_W-1];
      ow <= ovl_x[MAG_W-1:0];
      oh <= ovl_y[MAG_W-1:0];
    end
    if (cmd.mul) begin
      inter <= o_neg ? '0 : ow * oh;
      qarea <= qw * qh;
      tarea <= tw * th;
    end
    if (cmd.uni) begin
      uni <= UNI_W'({area_sum, 2'b00}) - inter;
    end
  end

  // Restoring divider, one quotient bit a cycle, or the saturated value on a full overlap; inter < uni on entry.
  always_ff @(posedge clk) begin
    if (cmd.sat) begin
      quo <= IOU_SAT;
    end else if (cmd.div_init) begin
      rem <= {1'b0, inter};
      quo <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      dcnt <= dcnt + 1'b1;
      if (rem2 >= {1'b0, uni}) begin
        rem <= rem2 - {1'b0, uni};
        quo <= {quo[IOU_W-2:0], 1'b1};
      end else begin
        rem <= rem2;
        quo <= {quo[IOU_W-2:0], 1'b0};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_best <= best;
      out_above <= (best > thr);
      out_cmp <= compared;
    end
  end

endmodule

### dv/biou_checker.sv
// Checker for the best-IoU box matcher: watches the item streams and config port,
// predicts each query result and compares it field by field. Depends on biou_pkg.
`timescale 1ns / 100ps

module biou_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int          fail_count,
  output int          pending_count
);
  import biou_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
  } box_t;

  typedef struct packed {
    logic [CMP_W-1:0] compared;
    logic             above;
    logic [IOU_W-1:0] iou;
  } match_t;

  box_t       truth_list[DEF_MAX_TRUTH_BOXES];
  int         truth_len;
  logic [IOU_W-1:0] threshold;
  match_t     expected_matches[$];

  // Overlap of two center-width intervals in doubled units.
  function automatic longint span_overlap(longint c1, longint s1, longint c2, longint s2);
    longint lo;
    longint hi;
    lo = (2 * c1 - s1 > 2 * c2 - s2) ? 2 * c1 - s1 : 2 * c2 - s2;
    hi = (2 * c1 + s1 < 2 * c2 + s2) ? 2 * c1 + s1 : 2 * c2 + s2;
    return hi - lo;
  endfunction

  // Best IoU of a predicted box against the stored list.
  function automatic match_t best_match(box_t q);
    match_t r;
    longint ow, oh, inter, uni, iou, best;
    int n;
    best = 0;
    r = '0;
    for (n = 0; n < truth_len; n++) begin
      if (truth_list[n].x <= 0) break;
      r.compared++;
      ow = span_overlap(q.x, q.w, truth_list[n].x, truth_list[n].w);
      oh = span_overlap(q.y, q.h, truth_list[n].y, truth_list[n].h);
      inter = (ow < 0 || oh < 0) ? 0 : ow * oh;
      uni = 4 * (longint'(q.w) * q.h + longint'(truth_list[n].w) * truth_list[n].h) - inter;
      if (uni <= 0) continue;
      iou = (inter <<< IOU_W) / uni;
      if (iou > 65535) iou = 65535;
      if (iou > best) best = iou;
    end
    r.iou = best[IOU_W-1:0];
    r.above = (r.iou > threshold);
    return r;
  endfunction

  assign pending_count = expected_matches.size();

  // Track state on accepted items and compare results.
  always @(posedge clk) begin
    box_t   b;
    match_t got;
    match_t exp_m;
    int     errs;
    errs = 0;
    if (rst) begin
      truth_len <= 0;
      threshold <= THRESH_RESET;
      fail_count <= 0;
      expected_matches.delete();
    end else begin
      if (cfg_wr_en) threshold <= cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        b.x = s_axis_tdata[17:0];
        b.y = s_axis_tdata[35:18];
        b.w = s_axis_tdata[52:36];
        b.h = s_axis_tdata[69:53];
        case (func_t'(s_axis_tuser))
          FUNC_CLEAR: truth_len <= 0;
          FUNC_APPEND: begin
            if (truth_len < DEF_MAX_TRUTH_BOXES) begin
              truth_list[truth_len] <= b;
              truth_len <= truth_len + 1;
            end
          end
          FUNC_QUERY: expected_matches.push_back(best_match(b));
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[22:0];
        if (expected_matches.size() == 0) begin
          $error("unexpected result item %h", m_axis_tdata);
          errs++;
        end else begin
          exp_m = expected_matches.pop_front();
          if (got.iou !== exp_m.iou) begin
            $error("top_iou expected %0d actual %0d", exp_m.iou, got.iou);
            errs++;
          end
          if (got.above !== exp_m.above) begin
            $error("above_threshold expected %0d actual %0d", exp_m.above, got.above);
            errs++;
          end
          if (got.compared !== exp_m.compared) begin
            $error("boxes_compared expected %0d actual %0d", exp_m.compared, got.compared);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

### dv/tb_best_iou_box_matcher.sv
// Testbench top for the best-IoU box matcher: clock, reset, stimulus and verdict.
// Depends on biou_pkg, best_iou_box_matcher and biou_checker.
`timescale 1ns / 100ps

module tb_best_iou_box_matcher;
  import biou_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  int          fail_count;
  int          pending_count;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off = 0;
  logic        long_stall = 1'b0;
  logic        stall_taken = 1'b0;

  always #2 clk = ~clk;

  best_iou_box_matcher u_top (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_wr_en, .cfg_wr_data
  );

  biou_checker u_checker (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_wr_en, .cfg_wr_data,
    .fail_count, .pending_count
  );

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (long_stall && !stall_taken) begin
      hold_off <= 400;
      stall_taken <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one item and wait until it is accepted; valid stays high afterwards.
  task automatic send_item(func_t f, logic [17:0] x, logic [17:0] y,
                           logic [16:0] w, logic [16:0] h);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= f;
    s_axis_tdata <= {2'b00, h, w, y, x};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Random box; mostly positive x with moderate sizes so that IoUs vary.
  task automatic send_random_box(func_t f);
    logic [17:0] x, y;
    logic [16:0] w, h;
    int r;
    r = $urandom_range(9);
    x = (r == 0) ? 18'($urandom) : 18'($urandom_range(60000, 1));
    y = (r == 1) ? 18'($urandom) : 18'($urandom_range(60000, 1));
    w = (r == 2) ? 17'($urandom) : 17'($urandom_range(40000));
    h = (r == 3) ? 17'($urandom) : 17'($urandom_range(40000));
    send_item(f, x, y, w, h);
  endtask

  // Stop offering, wait until idle, then write the threshold.
  task automatic write_threshold(logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Timeout.
  initial begin
    #40ms;
    $display("FAIL best_iou_box_matcher");
    $finish;
  end

  initial begin
    int phase;
    int k;
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty list, extremes, sentinel, identical and zero boxes, a full list.
    send_item(FUNC_QUERY, 18'd1000, 18'd1000, 17'd500, 17'd500);
    send_item(FUNC_APPEND, 18'd30000, 18'd30000, 17'd20000, 17'd20000);
    send_item(FUNC_QUERY, 18'd30000, 18'd30000, 17'd20000, 17'd20000);
    send_item(FUNC_APPEND, 18'h1FFFF, 18'h20000, 17'h1FFFF, 17'h1FFFF);
    send_item(FUNC_APPEND, 18'd5, 18'd5, 17'd0, 17'd0);
    send_item(FUNC_QUERY, 18'h20000, 18'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    send_item(FUNC_QUERY, 18'd5, 18'd5, 17'd0, 17'd0);
    send_item(FUNC_NONE, 18'h3FFFF, 18'h3FFFF, 17'h1FFFF, 17'h1FFFF);
    send_item(FUNC_APPEND, 18'd0, 18'd100, 17'd100, 17'd100);
    send_item(FUNC_APPEND, 18'd40000, 18'd100, 17'd100, 17'd100);
    send_item(FUNC_QUERY, 18'd40000, 18'd100, 17'd100, 17'd100);
    send_item(FUNC_CLEAR, 18'h3FFFF, 18'h3FFFF, 17'h1FFFF, 17'h1FFFF);
    send_item(FUNC_APPEND, 18'h3FFFF, 18'd100, 17'd100, 17'd100);
    send_item(FUNC_QUERY, 18'd1, 18'd100, 17'd100, 17'd100);
    send_item(FUNC_CLEAR, 18'd0, 18'd0, 17'd0, 17'd0);
    for (k = 0; k < 34; k++)
      send_item(FUNC_APPEND, 18'(100 + k * 10), 18'd50, 17'd30, 17'd30);
    send_item(FUNC_QUERY, 18'd200, 18'd50, 17'd30, 17'd30);

    // Threshold extremes, then random phases with different idling.
    write_threshold(16'd0);
    send_item(FUNC_QUERY, 18'd200, 18'd50, 17'd30, 17'd30);
    write_threshold(16'hFFFF);
    send_item(FUNC_QUERY, 18'd200, 18'd50, 17'd30, 17'd30);

    for (phase = 0; phase < 5; phase++) begin
      write_threshold(16'($urandom));
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; long_stall <= 1'b1; end
      endcase
      // Well-formed frames: clear, a few appends, several queries.
      for (n = 0; n < 22; n++) begin
        send_random_box(FUNC_CLEAR);
        for (k = $urandom_range(6, 0); k > 0; k--) send_random_box(FUNC_APPEND);
        if ($urandom_range(9) == 0)
          for (k = 0; k < 30; k++) send_random_box(FUNC_APPEND);
        for (k = $urandom_range(4, 1); k > 0; k--)
          send_random_box(($urandom_range(19) == 0) ? FUNC_NONE : FUNC_QUERY);
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS best_iou_box_matcher");
    end else begin
      $display("FAIL best_iou_box_matcher");
    end
    $finish;
  end

endmodule
